@@ hdl/text_console_writer_macros.svh @@
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// property holds at every edge out of reset
`define TCW_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TCW_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, codes, cell layout and control states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int ATTR_W = 8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  // register index, taken from paddr[2]
  localparam logic REG_ATTR = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SETCUR = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_PUT,
    ST_SEEK,
    ST_RESP
  } state_e;

endpackage

@@ hdl/tcw_if.sv @@
// ----------------------------------------------------------------------------
// Text console writer channels
// Command and response channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_cmd_if
  import tcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [POS_W-1:0]  cell_position;

  modport source (output valid, opcode, char_code, cell_position, input ready);
  modport sink   (input valid, opcode, char_code, cell_position, output ready);
endinterface

interface tcw_rsp_if
  import tcw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_now;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_now, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_now, cell_char, cell_attr, output ready);
endinterface

@@ hdl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ hdl/tcw_regs.sv @@
// ----------------------------------------------------------------------------
// Text console writer registers
// APB-style configuration port holding the text attribute.
// ----------------------------------------------------------------------------
module tcw_regs
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [ATTR_W-1:0] attr_o
);

  logic [ATTR_W-1:0] attr_q, attr_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ATTR);

  always_comb begin
    attr_d = attr_q;
    if (wr_en) begin
      attr_d = pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ATTR) begin
      prdata = APB_DW'(attr_q);
    end
  end

  assign attr_o = attr_q;

endmodule

@@ hdl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console writer control
// Sequencer over the screen RAM: put, scroll, clear, seek, read.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF,
  localparam int NCELLS = ROWS * COLS,
  localparam int AW     = $clog2(NCELLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_cmd_if.sink           cmd,
  tcw_rsp_if.source         rsp,
  input  logic [ATTR_W-1:0] attr_i,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output cell_t             ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  cell_t             ram_rdata_i
);

  localparam int CW    = $clog2(NCELLS + 1);
  localparam int CLW   = $clog2(COLS);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW-1:0]    NCELLS_C  = CW'(NCELLS);
  localparam logic [CW-1:0]    COLS_C    = CW'(COLS);
  localparam logic [CW:0]      COLS_X    = (CW + 1)'(COLS);
  localparam logic [CMP_W-1:0] NCELLS_X  = CMP_W'(NCELLS);
  localparam logic [AW-1:0]    COLS_A    = AW'(COLS);
  localparam logic [AW-1:0]    LASTROW_A = AW'(NCELLS - COLS);
  localparam logic [AW-1:0]    LAST_A    = AW'(NCELLS - 1);
  localparam logic [CLW-1:0]   COL_LAST  = CLW'(COLS - 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     base_q, base_d;
  logic [CLW-1:0]    col_q, col_d;
  logic [CW-1:0]     seek_q, seek_d;
  logic [CW-1:0]     target_q, target_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              wb_vld_q, wb_vld_d;
  logic [AW-1:0]     wb_addr_q, wb_addr_d;
  logic [CHAR_W-1:0] char_q, char_d;
  op_e               op_q, op_d;
  logic              rd_zero_q, rd_zero_d;
  logic              out_vld_q, out_vld_d;
  logic [POS_W-1:0]  out_cur_q, out_cur_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [ATTR_W-1:0] out_attr_q, out_attr_d;

  logic              accept;
  op_e               in_op;
  logic [CMP_W-1:0]  pos_x;
  logic              pos_in_range;
  logic [CW-1:0]     pos_sat;
  logic              do_put;
  logic [CHAR_W-1:0] put_char;
  logic              out_free;
  logic              seek_step;
  logic [CMP_W-1:0]  cursor_x;
  logic [CW-1:0]     seek_diff;

  assign cmd.ready    = (state_q == ST_IDLE);
  assign accept       = cmd.valid && cmd.ready;
  assign in_op        = op_e'(cmd.opcode);
  assign pos_x        = CMP_W'(cmd.cell_position);
  assign pos_in_range = (pos_x < NCELLS_X);
  assign pos_sat      = (pos_x > NCELLS_X) ? NCELLS_C : CW'(cmd.cell_position);
  assign out_free     = !out_vld_q || rsp.ready;
  assign seek_step    = ({1'b0, seek_q} + COLS_X) <= {1'b0, target_q};
  assign seek_diff    = target_q - seek_q;
  assign cursor_x     = CMP_W'(cursor_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (idx_q == LAST_A) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_PUT:    state_d = (cursor_q == NCELLS_C) ? ST_COPY : ST_RESP;
            OP_CLEAR:  state_d = ST_FILL;
            OP_SETCUR: state_d = ST_SEEK;
            OP_READ:   state_d = ST_RESP;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_FILL: begin
        if (idx_q == LAST_A) begin
          state_d = ST_RESP;
        end
      end
      ST_COPY: begin
        if (idx_q == LAST_A) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_BLANK;
      ST_BLANK: begin
        if (idx_q == LAST_A) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT:   state_d = ST_RESP;
      ST_SEEK: begin
        if (!seek_step) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_INIT;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cursor_d    = cursor_q;
    base_d      = base_q;
    col_d       = col_q;
    seek_d      = seek_q;
    target_d    = target_q;
    idx_d       = idx_q;
    wb_vld_d    = 1'b0;
    wb_addr_d   = wb_addr_q;
    char_d      = char_q;
    op_d        = op_q;
    rd_zero_d   = rd_zero_q;
    out_vld_d   = out_vld_q && !rsp.ready;
    out_cur_d   = out_cur_q;
    out_char_d  = out_char_q;
    out_attr_d  = out_attr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '{attr: attr_i, chr: BLANK_CODE};
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    do_put      = 1'b0;
    put_char    = char_q;

    unique case (state_q)
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        idx_d       = idx_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_d      = in_op;
          char_d    = cmd.char_code;
          rd_zero_d = !pos_in_range;
          unique case (in_op)
            OP_PUT: begin
              if (cursor_q == NCELLS_C) begin
                idx_d = COLS_A;
              end else begin
                do_put   = 1'b1;
                put_char = cmd.char_code;
              end
            end
            OP_CLEAR:  idx_d = '0;
            OP_SETCUR: begin
              target_d = pos_sat;
              seek_d   = '0;
            end
            OP_READ: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = AW'(cmd.cell_position);
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        ram_we_o = 1'b1;
        idx_d    = idx_q + AW'(1);
        if (idx_q == LAST_A) begin
          cursor_d = '0;
          base_d   = '0;
          col_d    = '0;
        end
      end
      ST_COPY: begin
        // read one row ahead, write back the word read last cycle
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q;
        wb_vld_d    = 1'b1;
        wb_addr_d   = idx_q - COLS_A;
        ram_we_o    = wb_vld_q;
        ram_waddr_o = wb_addr_q;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_q + AW'(1);
      end
      ST_DRAIN: begin
        ram_we_o    = wb_vld_q;
        ram_waddr_o = wb_addr_q;
        ram_wdata_o = ram_rdata_i;
        idx_d       = LASTROW_A;
      end
      ST_BLANK: begin
        ram_we_o = 1'b1;
        idx_d    = idx_q + AW'(1);
        if (idx_q == LAST_A) begin
          cursor_d = cursor_q - COLS_C;
          base_d   = base_q - COLS_C;
        end
      end
      ST_PUT:   do_put = 1'b1;
      ST_SEEK: begin
        if (seek_step) begin
          seek_d = seek_q + COLS_C;
        end else begin
          cursor_d = target_q;
          base_d   = seek_q;
          col_d    = CLW'(seek_diff);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_cur_d  = cursor_x[POS_W-1:0];
          out_char_d = '0;
          out_attr_d = '0;
          if (op_q == OP_READ && !rd_zero_q) begin
            out_char_d = ram_rdata_i.chr;
            out_attr_d = ram_rdata_i.attr;
          end
        end
      end
      default: ;
    endcase

    if (do_put) begin
      if (put_char == NEWLINE_CODE) begin
        cursor_d = base_q + COLS_C;
        base_d   = base_q + COLS_C;
        col_d    = '0;
      end else begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(cursor_q);
        ram_wdata_o = '{attr: attr_i, chr: put_char};
        cursor_d    = cursor_q + CW'(1);
        if (col_q == COL_LAST) begin
          col_d  = '0;
          base_d = base_q + COLS_C;
        end else begin
          col_d = col_q + CLW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cursor_q  <= '0;
      base_q    <= '0;
      col_q     <= '0;
      idx_q     <= '0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cursor_q  <= cursor_d;
      base_q    <= base_d;
      col_q     <= col_d;
      idx_q     <= idx_d;
      wb_vld_q  <= wb_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seek_q     <= seek_d;
    target_q   <= target_d;
    wb_addr_q  <= wb_addr_d;
    char_q     <= char_d;
    op_q       <= op_d;
    rd_zero_q  <= rd_zero_d;
    out_cur_q  <= out_cur_d;
    out_char_q <= out_char_d;
    out_attr_q <= out_attr_d;
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.cursor_now = out_cur_q;
  assign rsp.cell_char  = out_char_q;
  assign rsp.cell_attr  = out_attr_q;

  `TCW_ASSERT_ALWAYS(a_cursor_bound, clk_i, rst_ni, cursor_q <= NCELLS_C, "cursor past end")
  `TCW_ASSERT_ALWAYS(a_col_bound, clk_i, rst_ni, col_q <= COL_LAST, "column out of range")
  `TCW_ASSERT_ALWAYS(a_cursor_split, clk_i, rst_ni, cursor_q == base_q + CW'(col_q), "cursor split")
  `TCW_ASSERT_IMPL(a_wr_range, clk_i, rst_ni, ram_we_o, ram_waddr_o <= LAST_A, "write out of range")

endmodule

@@ hdl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// Text console writer
// Text screen of ROWS x COLS cells in one RAM plus a cursor.
//
//   channel  dir  word
//   cmd_in   in   opcode, char_code, cell_position
//   rsp_out  out  cursor_now, cell_char, cell_attr
//   apb      in   text_attribute at byte address 0
//
// Plain put, newline and read cell go from idle straight to the response.
// Set cursor: one row base step per cycle up to the target row.
// Clear fills every cell with blanks; put with scroll moves each row up
// one and blanks the last row; both are bound by the single RAM write port.
// After reset, a pass zeroes the RAM before cmd_in.ready rises.
// A stalled response is held; the next command is taken while it waits.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_cmd_if.sink           cmd_in,
  tcw_rsp_if.source         rsp_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);

  logic [ATTR_W-1:0] attr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  cell_t             ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  cell_t             ram_rdata;

  tcw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  tcw_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (NCELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd         (cmd_in),
    .rsp         (rsp_out),
    .attr_i      (attr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule
